### src/adm_pkg.sv
package adm_pkg;

  // Item kinds carried on the action field
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_JOY    = 2'd1,
    ACT_ENABLE = 2'd2,
    ACT_OTHER  = 2'd3
  } action_e;

  // Largest axis magnitude after clamping
  localparam int AXIS_MAX = 32767;

  // Axis value width after clamping
  localparam int AXIS_BITS = 16;

  // Queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);

  // Work handed from the front to the back: a zero axis pair with write set
  // yields the neutral pulse
  typedef struct packed {
    logic                        write;
    logic signed [AXIS_BITS-1:0] left;
    logic signed [AXIS_BITS-1:0] right;
    logic                        hb;
    logic                        enabled;
  } cmd_t;

endpackage

### src/arcade_drive_mixer_failsafe.sv
// Arcade drive mixer with motor failsafe and heartbeat timer.
//
// Input channel (in_valid_i / in_ready_o) carries one transaction per
// decoded radio packet or per one millisecond tick. Output channel
// (out_valid_o / out_ready_i) returns exactly one result per input
// transaction, in order: motor duties when a drive write happens, the
// heartbeat request and the enabled flag after that transaction.
// The APB port sets the station address (0x00), the motor timeout (0x08)
// and the heartbeat interval (0x10); write it only while the block is idle.
//
// The back end runs each transaction through a four-step duty sequencer
// (magnitude, scale, reciprocal divide, correct) and takes a new one only
// once the last has left that sequence. The front end takes a transaction
// when the queue has room and a two-entry queue buffers it, so up to four
// transactions may be in flight while the receiver stalls; in_ready_o drops
// only when the queue is full. Reset clears the enabled flag, the sender
// flag and both millisecond counters, and loads the register defaults.
module arcade_drive_mixer_failsafe #(
  parameter int DUTY_BITS = 14,
  parameter int TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  adm_pkg::action_e     action_i,
  input  logic signed [15:0]   axis_ly_i,
  input  logic signed [15:0]   axis_rx_i,
  input  logic [47:0]          target_address_i,
  input  logic [7:0]           enable_value_i,
  input  logic                 length_ok_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 drive_write_o,
  output logic [DUTY_BITS-1:0] left_duty_o,
  output logic [DUTY_BITS-1:0] right_duty_o,
  output logic                 heartbeat_send_o,
  output logic                 enabled_status_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);
  import adm_pkg::*;

  localparam logic [1:0] REG_OWN_ADDR = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_HB_INT   = 2'd2;

  logic [47:0] own_addr_q;
  logic [15:0] timeout_q;
  logic [15:0] hb_int_q;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  logic        push, full, pop, head_valid;
  cmd_t        push_cmd, head_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite;

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
      timeout_q  <= 16'd500;
      hb_int_q   <= 16'd1000;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OWN_ADDR: own_addr_q <= pwdata[47:0];
        REG_TIMEOUT:  timeout_q  <= pwdata[15:0];
        REG_HB_INT:   hb_int_q   <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_OWN_ADDR: prdata = 64'(own_addr_q);
      REG_TIMEOUT:  prdata = 64'(timeout_q);
      REG_HB_INT:   prdata = 64'(hb_int_q);
      default:      prdata = '0;
    endcase
  end

  adm_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .axis_ly_i           (axis_ly_i),
    .axis_rx_i           (axis_rx_i),
    .target_address_i    (target_address_i),
    .enable_value_i      (enable_value_i),
    .length_ok_i         (length_ok_i),
    .own_address_i       (own_addr_q),
    .motor_timeout_i     (timeout_q),
    .heartbeat_interval_i(hb_int_q),
    .full_i              (full),
    .push_o              (push),
    .cmd_o               (push_cmd)
  );

  adm_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .valid_o   (head_valid),
    .head_o    (head_cmd)
  );

  adm_back #(
    .DUTY_BITS(DUTY_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_write_o   (drive_write_o),
    .left_duty_o     (left_duty_o),
    .right_duty_o    (right_duty_o),
    .heartbeat_send_o(heartbeat_send_o),
    .enabled_status_o(enabled_status_o)
  );

endmodule

### src/adm_front.sv
module adm_front #(
  parameter int TIME_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  adm_pkg::action_e      action_i,
  input  logic signed [15:0]    axis_ly_i,
  input  logic signed [15:0]    axis_rx_i,
  input  logic [47:0]           target_address_i,
  input  logic [7:0]            enable_value_i,
  input  logic                  length_ok_i,
  input  logic [47:0]           own_address_i,
  input  logic [15:0]           motor_timeout_i,
  input  logic [15:0]           heartbeat_interval_i,
  input  logic                  full_i,
  output logic                  push_o,
  output adm_pkg::cmd_t         cmd_o
);
  import adm_pkg::*;

  localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic signed [17:0] SUM_HI = 18'(AXIS_MAX);
  localparam logic signed [17:0] SUM_LO = -SUM_HI;

  logic                 enabled_q, enabled_d;
  logic                 seen_q, seen_d;
  logic [TIME_BITS-1:0] sj_q, sj_d, sj_inc;
  logic [TIME_BITS-1:0] shb_q, shb_d, shb_inc;
  logic                 accept;
  logic                 addr_hit;
  logic signed [17:0]   fwd, sum_l, sum_r;
  cmd_t                 cmd;

  function automatic logic signed [AXIS_BITS-1:0] clamp_sum(logic signed [17:0] s);
    logic signed [17:0] c;
    c = s;
    if (s > SUM_HI) c = SUM_HI;
    if (s < SUM_LO) c = SUM_LO;
    return c[AXIS_BITS-1:0];
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;
  assign cmd_o      = cmd;

  // Mix the sticks into left and right drive values
  assign fwd   = -(18'(axis_ly_i));
  assign sum_l = fwd + 18'(axis_rx_i);
  assign sum_r = fwd - 18'(axis_rx_i);

  assign addr_hit = (target_address_i == '1) || (target_address_i == own_address_i);

  // Classify the transaction and work out the next state
  always_comb begin
    sj_inc  = (sj_q == TIME_MAX) ? sj_q : sj_q + TIME_BITS'(1);
    shb_inc = (shb_q == TIME_MAX) ? shb_q : shb_q + TIME_BITS'(1);
    enabled_d   = enabled_q;
    seen_d      = seen_q;
    sj_d        = sj_q;
    shb_d       = shb_q;
    cmd.write   = 1'b0;
    cmd.left    = '0;
    cmd.right   = '0;
    cmd.hb      = 1'b0;
    case (action_i)
      ACT_TICK: begin
        sj_d  = sj_inc;
        shb_d = shb_inc;
        if (enabled_q && (CW'(sj_inc) > CW'(motor_timeout_i))) begin
          cmd.write = 1'b1;
        end
        if (CW'(shb_inc) >= CW'(heartbeat_interval_i)) begin
          shb_d  = '0;
          cmd.hb = seen_q;
        end
      end
      ACT_JOY: begin
        seen_d = 1'b1;
        if (length_ok_i && enabled_q) begin
          sj_d      = '0;
          cmd.write = 1'b1;
          cmd.left  = clamp_sum(sum_l);
          cmd.right = clamp_sum(sum_r);
        end
      end
      ACT_ENABLE: begin
        seen_d = 1'b1;
        if (length_ok_i && addr_hit) begin
          enabled_d = (enable_value_i != 8'd0);
        end
      end
      default: begin
        seen_d = 1'b1;
      end
    endcase
    cmd.enabled = enabled_d;
  end

  // Hold the station state, advance it on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      seen_q    <= 1'b0;
      sj_q      <= '0;
      shb_q     <= '0;
    end else if (accept) begin
      enabled_q <= enabled_d;
      seen_q    <= seen_d;
      sj_q      <= sj_d;
      shb_q     <= shb_d;
    end
  end

  a_joy_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i == ACT_JOY && length_ok_i && enabled_q) |=> (sj_q == '0))
    else $error("accepted joystick did not clear the motor timer");

  a_short_keeps_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !length_ok_i) |=> (enabled_q == $past(enabled_q)))
    else $error("short packet changed the enabled flag");

endmodule

### src/adm_queue.sv
module adm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  adm_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output adm_pkg::cmd_t head_o
);
  import adm_pkg::*;

  cmd_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = (count_q == (PTR_W + 1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + (PTR_W + 1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (PTR_W + 1)'(1);
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W + 1)'(QDEPTH))
    else $error("queue fill level above depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o)
    else $error("push into full queue");

endmodule

### src/adm_back.sv
module adm_back #(
  parameter int DUTY_BITS = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  adm_pkg::cmd_t        head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 drive_write_o,
  output logic [DUTY_BITS-1:0] left_duty_o,
  output logic [DUTY_BITS-1:0] right_duty_o,
  output logic                 heartbeat_send_o,
  output logic                 enabled_status_o
);
  import adm_pkg::*;

  // Pulse mapping: 1500 +/- |v|*500/32767, duty = us*(2^DUTY_BITS-1)/20000
  localparam int NEUTRAL_US  = 1500;
  localparam int PULSE_SPAN  = 500;
  localparam int MAG_BITS    = 24;
  localparam int US_BITS     = 11;
  localparam int DUTY_FULL   = (1 << DUTY_BITS) - 1;
  // 20000 = 32 * 625: shift out the power of two, then divide by 625
  localparam int PERIOD_SHIFT = 5;
  localparam int PERIOD_ODD   = 625;
  localparam int RECIP_SHIFT  = 32;
  localparam int RECIP_ODD    = 6871947;
  localparam int PW  = US_BITS + DUTY_BITS;
  localparam int PDW = PW - PERIOD_SHIFT;
  localparam int QPW = PDW + 23;
  localparam int QW  = QPW - RECIP_SHIFT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                state_q;
  logic [MAG_BITS-1:0]   m_q    [2];
  logic                  neg_q  [2];
  logic [PDW-1:0]        pdiv_q [2];
  logic [QW-1:0]         qe_q   [2];
  logic                  write_q, hb_q, en_q;

  logic                  out_valid_q;
  logic                  drive_write_q, hb_out_q, en_out_q;
  logic [DUTY_BITS-1:0]  left_q, right_q;

  logic signed [AXIS_BITS-1:0] axis   [2];
  logic [AXIS_BITS-1:0]        absv   [2];
  logic [MAG_BITS-1:0]         m_d    [2];
  logic [8:0]                  q0     [2];
  logic [15:0]                 rem_a  [2];
  logic [9:0]                  quo    [2];
  logic [US_BITS-1:0]          us     [2];
  logic [PW-1:0]               prod   [2];
  logic [QPW-1:0]              prod_q [2];
  logic [PDW-1:0]              rem_b  [2];
  logic [DUTY_BITS-1:0]        duty   [2];
  logic                        out_free;

  assign axis[0]  = head_i.left;
  assign axis[1]  = head_i.right;
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == ST_IDLE) && head_valid_i;

  // Per-lane datapath for each step of the sequence
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      absv[l]   = axis[l][AXIS_BITS-1] ? AXIS_BITS'(-axis[l]) : AXIS_BITS'(axis[l]);
      m_d[l]    = MAG_BITS'(absv[l][AXIS_BITS-2:0]) * MAG_BITS'(PULSE_SPAN);
      // Divide by 32767 = 2^15 - 1 with one correction step
      q0[l]     = m_q[l][MAG_BITS-1:15];
      rem_a[l]  = 16'(m_q[l][14:0]) + 16'(q0[l]);
      quo[l]    = 10'(q0[l]) + ((rem_a[l] >= 16'(AXIS_MAX)) ? 10'd1 : 10'd0);
      us[l]     = neg_q[l] ? US_BITS'(NEUTRAL_US) - US_BITS'(quo[l])
                           : US_BITS'(NEUTRAL_US) + US_BITS'(quo[l]);
      prod[l]   = PW'(us[l]) * PW'(DUTY_FULL);
      prod_q[l] = QPW'(pdiv_q[l]) * QPW'(RECIP_ODD);
      rem_b[l]  = pdiv_q[l] - PDW'(PDW'(qe_q[l]) * PDW'(PERIOD_ODD));
      duty[l]   = DUTY_BITS'(qe_q[l])
                + ((rem_b[l] >= PDW'(PERIOD_ODD)) ? DUTY_BITS'(1) : DUTY_BITS'(0));
    end
  end

  // Sequence one command through magnitude, scale, divide and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // Raise the result when the sequence ends, drop it once taken
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            for (int l = 0; l < 2; l++) begin
              m_q[l]   <= m_d[l];
              neg_q[l] <= axis[l][AXIS_BITS-1];
            end
            write_q <= head_i.write;
            hb_q    <= head_i.hb;
            en_q    <= head_i.enabled;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          for (int l = 0; l < 2; l++) begin
            pdiv_q[l] <= prod[l][PW-1:PERIOD_SHIFT];
          end
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          for (int l = 0; l < 2; l++) begin
            qe_q[l] <= prod_q[l][QPW-1:RECIP_SHIFT];
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            drive_write_q <= write_q;
            left_q        <= write_q ? duty[0] : '0;
            right_q       <= write_q ? duty[1] : '0;
            hb_out_q      <= hb_q;
            en_out_q      <= en_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_write_o    = drive_write_q;
  assign left_duty_o      = left_q;
  assign right_duty_o     = right_q;
  assign heartbeat_send_o = hb_out_q;
  assign enabled_status_o = en_out_q;

  a_idle_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !drive_write_o) |-> (left_duty_o == '0 && right_duty_o == '0))
    else $error("duty nonzero on a result without a drive write");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ready_i) |=> (state_q == ST_FIN))
    else $error("result step left while the output was still held");

endmodule
